[sv/spring_damper_shake_bank_assert.svh]
// Assertion macros shared by the shake bank RTL.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef SPRING_DAMPER_SHAKE_BANK_ASSERT_SVH
`define SPRING_DAMPER_SHAKE_BANK_ASSERT_SVH

// Same-cycle implication.
`define SDSB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sdsb_pkg.sv]
package sdsb_pkg;

    localparam int PARTS = 16;
    localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CNT_W = $clog2(PARTS + 1);
    localparam logic [6:0] PARTS_7 = 7'(PARTS);

    localparam int ACC_W = 44;
    localparam logic signed [ACC_W-1:0] ACC_STIFF = 44'sd2000;
    localparam logic signed [ACC_W-1:0] ACC_DAMP  = 44'sd12;
    localparam logic signed [32:0] NEAR_ZERO = 33'sd6553;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_TRIG_RD,
        ST_TRIG_WR
    } state_t;

    // one stored part: remaining time, velocity, angle
    typedef struct packed {
        logic        [23:0] rem;
        logic signed [31:0] vel;
        logic signed [31:0] ang;
    } part_state_t;

    localparam int STATE_W = $bits(part_state_t);

    // a part travelling through the update pipeline
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               near;
        logic        [23:0] rem;
        logic signed [31:0] a;
        logic signed [31:0] v;
    } lane_t;

    function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
        logic signed [31:0] r;
        if (x > 45'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -45'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[sv/spring_damper_shake_bank.sv]
// Bank of damped springs, one per part, updated by semi-implicit Euler steps.
// Input channel (item_valid / item_stall) carries one word per item: kind selects
// a tick (delta_time) or a trigger (part_index, impulse, duration). A trigger
// with a positive impulse on an existing part kicks its velocity, reloads its
// shake time and grows the active count; other triggers are dropped.
// A tick walks parts 0 .. count-1 and sends one result word per part on the
// output channel (result_valid / result_stall): part_number, shake_angle and
// last on the final part. A tick with no active parts sends nothing.
// Part state sits in one RAM word per part; a five-stage update pipeline reads
// one part per cycle while the output is not stalled and writes it back at the end.
// No item is accepted while a tick or a trigger is in progress: a tick finishes
// all of its parts before the next item is taken. A trigger reads the part from
// RAM, writes it back and returns to idle.
// write_enable / write_data set the active count to min(write_data, 16) and
// clear parts at and beyond it. Reset clears all parts and the count at once.
// A stalled receiver freezes the whole pipeline; no result is lost or repeated.
`include "spring_damper_shake_bank_assert.svh"

module spring_damper_shake_bank (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               kind,
    input  logic        [15:0] delta_time,
    input  logic        [5:0]  part_index,
    input  logic signed [31:0] impulse,
    input  logic        [23:0] duration,
    output logic               result_valid,
    input  logic               result_stall,
    output logic        [5:0]  part_number,
    output logic signed [31:0] shake_angle,
    output logic               last,
    input  logic               write_enable,
    input  logic        [6:0]  write_data
);

    localparam int IW = sdsb_pkg::IDX_W;
    localparam int CW = sdsb_pkg::CNT_W;

    sdsb_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              grown_count_reg, grown_count_next;
    logic [CW-1:0]              issue_idx_reg, issue_idx_next;
    logic [sdsb_pkg::PARTS-1:0] part_valid_reg, part_valid_next;
    logic [4:0]                 pipe_valid_reg, pipe_valid_next;
    logic                       result_valid_reg, result_valid_next;

    logic        [15:0] dt_reg;
    logic [IW-1:0]      trig_idx_reg;
    logic signed [31:0] trig_imp_reg;
    logic        [23:0] trig_dur_reg;
    logic               vmask_rd_reg;

    logic [IW-1:0] s1_idx_reg;
    logic          s1_last_reg;
    sdsb_pkg::lane_t s2_lane_reg, s3_lane_reg, s4_lane_reg, s5_lane_reg;
    sdsb_pkg::lane_t s2_lane_next, s4_lane_next, s5_out;
    logic                  s2_neg_reg;
    logic [sdsb_pkg::ACC_W-2:0] s2_mag_reg;
    logic signed [sdsb_pkg::ACC_W-1:0] s3_p1_reg, s3_p1_next;
    logic signed [33:0]    s5_p2_reg, s5_p2_next;

    logic [5:0]         part_number_reg;
    logic signed [31:0] shake_angle_reg;
    logic               last_reg;

    // control
    logic accept, trig_ok, adv, issue, pipe_empty, issue_done;
    logic [CW-1:0] cfg_count, trig_count;

    // RAM port
    logic                     ram_we, ram_re;
    logic [IW-1:0]            ram_waddr, ram_raddr;
    logic [sdsb_pkg::STATE_W-1:0] ram_wdata, ram_rdata;

    // datapath
    sdsb_pkg::part_state_t rd_state, wb_state, trig_state;
    logic signed [32:0]    s1_abs_a;
    logic signed [sdsb_pkg::ACC_W-1:0] s1_a_ext, s1_v_ext, s1_acc, s1_acc_mag;
    logic [59:0]           s2_prod;
    logic [sdsb_pkg::ACC_W-2:0] s2_rnd;
    logic signed [44:0]    s3_sum;
    logic signed [31:0]    s3_vnew;
    logic signed [32:0]    s4_v_ext, s4_vabs;
    logic [48:0]           s4_prod;
    logic [32:0]           s4_rnd;
    logic signed [44:0]    s5_sum;
    logic signed [44:0]    trig_sum;

    sdsb_ram #(
        .WIDTH (sdsb_pkg::STATE_W),
        .DEPTH (sdsb_pkg::PARTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept     = item_valid && !item_stall;
    assign trig_ok    = (impulse > 32'sd0) && ({1'b0, part_index} < sdsb_pkg::PARTS_7);
    assign adv        = !result_valid_reg || !result_stall;
    assign pipe_empty = (pipe_valid_reg == 5'd0);
    assign issue_done = (issue_idx_reg >= grown_count_reg);
    assign cfg_count  = (write_data > sdsb_pkg::PARTS_7) ? CW'(sdsb_pkg::PARTS)
                                                         : CW'(write_data);
    assign trig_count = CW'(part_index[IW-1:0]) + CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdsb_pkg::ST_IDLE:
            begin
                if (accept && kind == sdsb_pkg::KIND_TICK)
                begin
                    state_next = sdsb_pkg::ST_RUN;
                end
                else if (accept && trig_ok)
                begin
                    state_next = sdsb_pkg::ST_TRIG_RD;
                end
            end
            sdsb_pkg::ST_RUN:
            begin
                if (issue_done && pipe_empty)
                begin
                    state_next = sdsb_pkg::ST_IDLE;
                end
            end
            sdsb_pkg::ST_TRIG_RD:
            begin
                state_next = sdsb_pkg::ST_TRIG_WR;
            end
            sdsb_pkg::ST_TRIG_WR:
            begin
                state_next = sdsb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sdsb_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs and RAM port
    always_comb
    begin
        item_stall = 1'b1;
        issue      = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = trig_idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = s5_lane_reg.idx;
        ram_wdata  = wb_state;
        case (state_reg)
            sdsb_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            sdsb_pkg::ST_RUN:
            begin
                issue     = !issue_done;
                ram_re    = adv && !issue_done;
                ram_raddr = issue_idx_reg[IW-1:0];
                ram_we    = adv && pipe_valid_reg[4];
            end
            sdsb_pkg::ST_TRIG_RD:
            begin
                ram_re = 1'b1;
            end
            sdsb_pkg::ST_TRIG_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = trig_idx_reg;
                ram_wdata = trig_state;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_comb
    begin
        grown_count_next = grown_count_reg;
        if (write_enable)
        begin
            grown_count_next = cfg_count;
        end
        else if (accept && kind == sdsb_pkg::KIND_TRIGGER && trig_ok
                 && grown_count_reg < trig_count)
        begin
            grown_count_next = trig_count;
        end

        issue_idx_next = issue_idx_reg;
        if (accept)
        begin
            issue_idx_next = '0;
        end
        else if (adv && issue)
        begin
            issue_idx_next = issue_idx_reg + CW'(1);
        end

        part_valid_next = part_valid_reg;
        if (ram_we)
        begin
            part_valid_next[ram_waddr] = 1'b1;
        end
        if (write_enable)
        begin
            for (int i = 0; i < sdsb_pkg::PARTS; i++)
            begin
                if (CW'(i) >= cfg_count)
                begin
                    part_valid_next[i] = 1'b0;
                end
            end
        end

        pipe_valid_next = adv ? {pipe_valid_reg[3:0], issue} : pipe_valid_reg;
        result_valid_next = (adv && pipe_valid_reg[4]) || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sdsb_pkg::ST_IDLE;
            grown_count_reg  <= '0;
            issue_idx_reg    <= '0;
            part_valid_reg   <= '0;
            pipe_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            grown_count_reg  <= grown_count_next;
            issue_idx_reg    <= issue_idx_next;
            part_valid_reg   <= part_valid_next;
            pipe_valid_reg   <= pipe_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // stage 1: masked read, near-zero test, spring force
    assign rd_state = vmask_rd_reg ? sdsb_pkg::part_state_t'(ram_rdata) : '0;

    always_comb
    begin
        s1_a_ext   = sdsb_pkg::ACC_W'(rd_state.ang);
        s1_v_ext   = sdsb_pkg::ACC_W'(rd_state.vel);
        s1_abs_a   = s1_a_ext[32:0];
        if (s1_abs_a < 0)
        begin
            s1_abs_a = -s1_abs_a;
        end
        s1_acc     = -(s1_a_ext * sdsb_pkg::ACC_STIFF) - (s1_v_ext * sdsb_pkg::ACC_DAMP);
        s1_acc_mag = s1_acc[sdsb_pkg::ACC_W-1] ? -s1_acc : s1_acc;

        s2_lane_next.idx  = s1_idx_reg;
        s2_lane_next.last = s1_last_reg;
        s2_lane_next.near = (rd_state.rem == 24'd0) && (s1_abs_a <= sdsb_pkg::NEAR_ZERO);
        s2_lane_next.rem  = rd_state.rem;
        s2_lane_next.a    = rd_state.ang;
        s2_lane_next.v    = rd_state.vel;
    end

    // stage 2: velocity increment, rounded half away from zero
    always_comb
    begin
        s2_prod    = 60'(s2_mag_reg) * 60'(dt_reg) + 60'd32768;
        s2_rnd     = s2_prod[sdsb_pkg::ACC_W+14:16];
        s3_p1_next = s2_neg_reg ? -sdsb_pkg::ACC_W'({1'b0, s2_rnd})
                                :  sdsb_pkg::ACC_W'({1'b0, s2_rnd});
    end

    // stage 3: new velocity
    always_comb
    begin
        s3_sum       = 45'(s3_lane_reg.v) + 45'(s3_p1_reg);
        s3_vnew      = sdsb_pkg::sat32(s3_sum);
        s4_lane_next = s3_lane_reg;
        s4_lane_next.v = s3_lane_reg.near ? 32'sd0 : s3_vnew;
    end

    // stage 4: angle increment
    always_comb
    begin
        s4_v_ext   = 33'(s4_lane_reg.v);
        s4_vabs    = (s4_v_ext < 0) ? -s4_v_ext : s4_v_ext;
        s4_prod    = 49'(s4_vabs) * 49'(dt_reg) + 49'd32768;
        s4_rnd     = {1'b0, s4_prod[47:16]};
        s5_p2_next = (s4_v_ext < 0) ? -34'({1'b0, s4_rnd}) : 34'({1'b0, s4_rnd});
    end

    // stage 5: new angle and remaining time, write back
    always_comb
    begin
        s5_sum = 45'(s5_lane_reg.a) + 45'(s5_p2_reg);
        s5_out = s5_lane_reg;
        if (s5_lane_reg.near)
        begin
            s5_out.a = 32'sd0;
        end
        else
        begin
            s5_out.a   = sdsb_pkg::sat32(s5_sum);
            s5_out.rem = (s5_lane_reg.rem > 24'(dt_reg)) ? s5_lane_reg.rem - 24'(dt_reg)
                                                         : 24'd0;
        end
        wb_state.rem = s5_out.rem;
        wb_state.vel = s5_out.v;
        wb_state.ang = s5_out.a;
    end

    // trigger update
    always_comb
    begin
        trig_sum       = 45'(rd_state.vel) + 45'(trig_imp_reg);
        trig_state.rem = trig_dur_reg;
        trig_state.vel = sdsb_pkg::sat32(trig_sum);
        trig_state.ang = rd_state.ang;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg       <= delta_time;
            trig_idx_reg <= part_index[IW-1:0];
            trig_imp_reg <= impulse;
            trig_dur_reg <= duration;
        end
        if (ram_re)
        begin
            vmask_rd_reg <= part_valid_reg[ram_raddr];
        end
        if (adv)
        begin
            s1_idx_reg  <= issue_idx_reg[IW-1:0];
            s1_last_reg <= (issue_idx_reg + CW'(1)) == grown_count_reg;
            s2_lane_reg <= s2_lane_next;
            s2_neg_reg  <= s1_acc[sdsb_pkg::ACC_W-1];
            s2_mag_reg  <= s1_acc_mag[sdsb_pkg::ACC_W-2:0];
            s3_lane_reg <= s2_lane_reg;
            s3_p1_reg   <= s3_p1_next;
            s4_lane_reg <= s4_lane_next;
            s5_lane_reg <= s4_lane_reg;
            s5_p2_reg   <= s5_p2_next;
        end
        if (adv && pipe_valid_reg[4])
        begin
            part_number_reg <= 6'(s5_out.idx);
            shake_angle_reg <= s5_out.a;
            last_reg        <= s5_out.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign part_number  = part_number_reg;
    assign shake_angle  = shake_angle_reg;
    assign last         = last_reg;

    `SDSB_ASSERT_IMPLY(a_pipe_only_in_run, (|pipe_valid_reg), (state_reg == sdsb_pkg::ST_RUN), "pipeline busy outside a tick")
    `SDSB_ASSERT_NEXT(a_tail_held, (pipe_valid_reg[4] && !adv), (pipe_valid_reg[4]), "pipeline tail dropped while output stalled")
    `SDSB_ASSERT_IMPLY(a_write_state, ram_we, (state_reg == sdsb_pkg::ST_RUN || state_reg == sdsb_pkg::ST_TRIG_WR), "state RAM written outside run or trigger write")
    `SDSB_ASSERT_IMPLY(a_count_range, 1'b1, (grown_count_reg <= CW'(sdsb_pkg::PARTS)), "active count beyond part bank")

endmodule

[sv/sdsb_ram.sv]
module sdsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
